### rtl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rqd_pkg.sv
// ---------------------------------------------------------------------------
// Ready queue dispatcher package
// Shared types and codes for the ready queue dispatcher.
// ---------------------------------------------------------------------------
package rqd_pkg;

  localparam logic [1:0] FCFS       = 2'd0;
  localparam logic [1:0] RR         = 2'd1;
  localparam logic [1:0] SJF        = 2'd2;
  // The spare mode code dispatches like first come first served.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] ST_INSERTED   = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic CFG_SCHED_MODE = 1'b0;
  localparam logic CFG_TIME_SLICE = 1'b1;

  localparam logic [15:0] TIME_SLICE_RESET = 16'd50;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  thread_id;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  out_thread;
    logic [15:0] run_time;
    logic [15:0] remaining_time;
    logic        job_finished;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_DONE
  } exec_state_t;

endpackage

### rtl/ready_queue_dispatcher_top.sv
// An insert or an empty dispatch goes from the idle state straight to the result register;
// a job dispatch passes the scan, pick and done states, with shift states between pick and
// done when SJF picks a slot behind the head. SJF scans every queued job. Throughput: one
// insert per cycle while the output does not stall; a job dispatch holds the engine busy.
// A two-entry front queue and an output register let both ports stall on their own.
// Reset (rst, synchronous) empties the queue and sets FCFS with slice 50.
// ---------------------------------------------------------------------------
// Ready queue dispatcher top level
// Configuration registers, front queue and execution engine.
// ---------------------------------------------------------------------------
module ready_queue_dispatcher_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rqd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rqd_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic              cmd_valid;
  logic              cmd_take;
  rqd_pkg::in_item_t cmd_item;
  logic [1:0]        sched_mode;
  logic [15:0]       time_slice;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= rqd_pkg::FCFS;
      time_slice <= rqd_pkg::TIME_SLICE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rqd_pkg::CFG_SCHED_MODE: sched_mode <= cfg_data[1:0];
        rqd_pkg::CFG_TIME_SLICE: time_slice <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rqd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd_item (cmd_item)
  );

  rqd_exec #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_item  (cmd_item),
    .sched_mode(sched_mode),
    .time_slice(time_slice),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### rtl/rqd_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rqd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rqd_front.sv
// ---------------------------------------------------------------------------
// Ready queue dispatcher front end
// Two-entry queue of accepted transactions between the input port and the
// execution engine.
// ---------------------------------------------------------------------------
module rqd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rqd_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output rqd_pkg::in_item_t cmd_item
);

  rqd_pkg::in_item_t buf_item [2];
  logic              rd_ptr;
  logic              wr_ptr;
  logic [1:0]        fill;
  logic              push;
  logic              pop;

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd_item  = buf_item[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_item[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/rqd_exec.sv
// ---------------------------------------------------------------------------
// Ready queue dispatcher execution engine
// Keeps the queue in a RAM as a circular buffer, scans for the shortest job
// in SJF, closes gaps one slot per cycle and holds the result for the output port.
// ---------------------------------------------------------------------------
module rqd_exec #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  rqd_pkg::in_item_t  cmd_item,
  input  logic [1:0]         sched_mode,
  input  logic [15:0]        time_slice,
  output logic               out_valid,
  input  logic               out_stall,
  output rqd_pkg::out_item_t out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(QUEUE_DEPTH - 1);

  rqd_pkg::exec_state_t state, state_next;

  logic [AW-1:0] head;
  logic [CW-1:0] job_count;
  logic [CW-1:0] issue_idx;
  logic [CW-1:0] rd_off;
  logic          rd_pend;
  logic [CW-1:0] scan_len;
  logic [CW-1:0] pick;
  logic [CW-1:0] dst;
  logic [15:0]   best;
  logic [3:0]    best_thread;
  logic          is_rr;
  logic          is_sjf;
  logic          rotate;
  logic          full_buf;
  logic          out_full;
  logic          out_free;
  logic          res_load;
  rqd_pkg::out_item_t res;

  logic          we;
  logic [AW-1:0] waddr;
  logic [19:0]   wdata;
  logic [AW-1:0] raddr;
  logic [19:0]   rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {1'b0, CW'(base)} + {1'b0, off};
    if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW + 1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic rqd_pkg::out_item_t mk_res(input logic [1:0]  st,
                                                input logic [3:0]  th,
                                                input logic [15:0] run,
                                                input logic [15:0] rem,
                                                input logic        fin);
    rqd_pkg::out_item_t r;
    r.status         = st;
    r.out_thread     = th;
    r.run_time       = run;
    r.remaining_time = rem;
    r.job_finished   = fin;
    return r;
  endfunction

  rqd_ram #(.WIDTH(20), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign is_rr     = (sched_mode == rqd_pkg::RR);
  assign is_sjf    = (sched_mode == rqd_pkg::SJF);
  assign rotate    = is_rr && (best > time_slice);
  assign scan_len  = is_sjf ? job_count : CW'(1);
  assign full_buf  = (job_count == FULL_COUNT);
  // The result register can take a new result when it is empty or drains now.
  assign out_free  = !out_full || !out_stall;
  assign cmd_take  = (state == rqd_pkg::S_IDLE) && cmd_valid && out_free;
  assign res_load  = ((state == rqd_pkg::S_IDLE) && cmd_take &&
                      (cmd_item.cmd == rqd_pkg::CMD_INSERT || job_count == '0)) ||
                     (state == rqd_pkg::S_DONE);
  assign out_valid = out_full;
  assign out_item  = res;

  always_comb begin
    state_next = state;
    case (state)
      rqd_pkg::S_IDLE: begin
        if (cmd_take && cmd_item.cmd == rqd_pkg::CMD_DISPATCH && job_count != '0) begin
          state_next = rqd_pkg::S_SCAN;
        end
      end
      rqd_pkg::S_SCAN: begin
        if (rd_pend && issue_idx == scan_len) begin
          state_next = rqd_pkg::S_PICK;
        end
      end
      rqd_pkg::S_PICK: begin
        state_next = (pick == '0) ? rqd_pkg::S_DONE : rqd_pkg::S_SHIFT;
      end
      rqd_pkg::S_SHIFT: begin
        if (dst == CW'(1)) begin
          state_next = rqd_pkg::S_DONE;
        end
      end
      rqd_pkg::S_DONE: begin
        state_next = rqd_pkg::S_IDLE;
      end
      default: begin
        state_next = rqd_pkg::S_IDLE;
      end
    endcase
  end

  // RAM port control.
  always_comb begin
    we    = 1'b0;
    waddr = slot(head, job_count);
    wdata = {cmd_item.thread_id, cmd_item.burst_time};
    raddr = slot(head, issue_idx);
    case (state)
      rqd_pkg::S_IDLE: begin
        we = cmd_take && cmd_item.cmd == rqd_pkg::CMD_INSERT && !full_buf;
      end
      rqd_pkg::S_PICK: begin
        raddr = slot(head, pick - CW'(1));
      end
      rqd_pkg::S_SHIFT: begin
        // Slot dst takes the entry read from slot dst-1 (toward the head).
        we    = 1'b1;
        waddr = slot(head, dst);
        wdata = rdata;
        raddr = slot(head, dst - CW'(2));
      end
      rqd_pkg::S_DONE: begin
        // The freed head slot is the new tail slot when the queue was full.
        we    = rotate;
        waddr = slot(head, job_count);
        wdata = {best_thread, best - time_slice};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rqd_pkg::S_IDLE;
      head      <= '0;
      job_count <= '0;
      out_full  <= 1'b0;
      rd_pend   <= 1'b0;
      issue_idx <= '0;
      res       <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_full <= 1'b1;
      end else if (out_full && !out_stall) begin
        out_full <= 1'b0;
      end
      case (state)
        rqd_pkg::S_IDLE: begin
          issue_idx <= '0;
          rd_pend   <= 1'b0;
          if (cmd_take) begin
            if (cmd_item.cmd == rqd_pkg::CMD_INSERT) begin
              if (full_buf) begin
                res <= mk_res(rqd_pkg::ST_FULL, '0, '0, '0, 1'b0);
              end else begin
                res       <= mk_res(rqd_pkg::ST_INSERTED, '0, '0, '0, 1'b0);
                job_count <= job_count + CW'(1);
              end
            end else if (job_count == '0) begin
              res <= mk_res(rqd_pkg::ST_EMPTY, '0, '0, '0, 1'b0);
            end
          end
        end
        rqd_pkg::S_SCAN: begin
          // One slot a cycle; the read issued last cycle returns now.
          if (rd_pend && (rd_off == '0 || rdata[15:0] < best)) begin
            best        <= rdata[15:0];
            best_thread <= rdata[19:16];
            pick        <= rd_off;
          end
          if (issue_idx != scan_len) begin
            rd_pend   <= 1'b1;
            rd_off    <= issue_idx;
            issue_idx <= issue_idx + CW'(1);
          end else begin
            rd_pend <= 1'b0;
          end
        end
        rqd_pkg::S_PICK: begin
          dst <= pick;
        end
        rqd_pkg::S_SHIFT: begin
          dst <= dst - CW'(1);
        end
        rqd_pkg::S_DONE: begin
          head <= (head == LAST_SLOT) ? '0 : head + AW'(1);
          if (rotate) begin
            res <= mk_res(rqd_pkg::ST_DISPATCHED, best_thread, time_slice,
                          best - time_slice, 1'b0);
          end else begin
            res       <= mk_res(rqd_pkg::ST_DISPATCHED, best_thread, best, '0, 1'b1);
            job_count <= job_count - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/rqd_checker.sv
// ---------------------------------------------------------------------------
// Ready queue dispatcher port checker
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rqd_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input rqd_pkg::out_item_t out_item
);

  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
  `CHK_IMPLY(a_fin_rem, clk, rst, out_valid && out_item.job_finished, out_item.remaining_time == '0, "finished job has time left")
  `CHK_IMPLY(a_nodisp_zero, clk, rst, out_valid && out_item.status != rqd_pkg::ST_DISPATCHED, out_item.run_time == '0 && !out_item.job_finished, "non-dispatch result carries data")

endmodule

bind ready_queue_dispatcher_top rqd_checker u_rqd_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
